// File: design/fpr_pkg.sv
// Shared types, constants and helpers for the frame pacer with rate meter.
// Used by fpr_alu and frame_pacer_with_rate_meter; no dependencies of its own.
package fpr_pkg;

   // Ring depth, frames averaged by the rate meter
   localparam int WINDOW = 64;

   // Field widths
   localparam int TIME_W = 48;
   localparam int DUR_W  = 32;
   localparam int RATE_W = 32;

   // Derived state widths
   localparam int HEAD_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SEEN_W  = $clog2(WINDOW + 1);
   localparam int TOTAL_W = DUR_W + $clog2(WINDOW);

   // Rate numerator: 1e9 * WINDOW * 256 (Q24.8 frames per second)
   localparam longint unsigned NS_PER_SEC = 64'd1000000000;
   localparam longint unsigned RATE_NUM_L = NS_PER_SEC * WINDOW * 256;
   localparam int NUM_W   = $clog2(RATE_NUM_L + 1);
   localparam int DCNT_W  = $clog2(NUM_W);
   localparam logic [NUM_W-1:0] RATE_NUM = NUM_W'(RATE_NUM_L);

   // Shared adder operation
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // Sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_ADV  = 8'b0000_0010,
      ST_CMP  = 8'b0000_0100,
      ST_RST  = 8'b0000_1000,
      ST_SUB  = 8'b0001_0000,
      ST_ADD  = 8'b0010_0000,
      ST_DIV  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   // Saturate a 48-bit time difference to 32 bits
   function automatic logic [DUR_W-1:0] sat_dur(input logic [TIME_W-1:0] diff);
      logic [DUR_W-1:0] res;
      res = (|diff[TIME_W-1:DUR_W]) ? {DUR_W{1'b1}} : diff[DUR_W-1:0];
      return res;
   endfunction

endpackage

// File: design/fpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fpr_alu.sv
// Shared 48-bit add/subtract unit with carry out (carry set on subtract means a >= b).
// Depends on fpr_pkg.
module fpr_alu (
   input  fpr_pkg::alu_op_type               op,
   input  logic [fpr_pkg::TIME_W-1:0]        a,
   input  logic [fpr_pkg::TIME_W-1:0]        b,
   output logic [fpr_pkg::TIME_W-1:0]        sum,
   output logic                              carry
);

   logic [fpr_pkg::TIME_W-1:0] b_eff;
   logic                       sub;

   // Two's complement subtract via inverted operand and carry in
   assign sub   = (op == fpr_pkg::ALU_SUB);
   assign b_eff = sub ? ~b : b;
   assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{fpr_pkg::TIME_W{1'b0}}, sub};

endmodule

// File: design/frame_pacer_with_rate_meter.sv
// Frame pacer with rate meter: one request in, one response out.
// Steps: ADV and CMP if paced, RST if the deadline fell behind, SUB, ADD, DIV once the
// window is full, then DONE; one request at a time; the adder does all the arithmetic.
// The response register frees req_ready while a response waits to be taken.
// Reset (synchronous, active high) clears deadline, ring head, sum, fill count, rate.
// Depends on fpr_pkg, fpr_alu, fpr_ram.
module frame_pacer_with_rate_meter (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fpr_pkg::DUR_W-1:0]         csr_frame_budget_ns,
   // requests
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fpr_pkg::TIME_W-1:0]        req_now_ns,
   // responses
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fpr_pkg::TIME_W-1:0]        rsp_release_ns,
   output logic [fpr_pkg::DUR_W-1:0]         rsp_wait_ns,
   output logic [fpr_pkg::RATE_W-1:0]        rsp_measured_rate_q8,
   output logic                              rsp_rate_valid
);

   localparam int TW = fpr_pkg::TIME_W;
   localparam int DW = fpr_pkg::DUR_W;
   localparam int RW = fpr_pkg::RATE_W;
   localparam int HW = fpr_pkg::HEAD_W;
   localparam int SW = fpr_pkg::SEEN_W;
   localparam int OW = fpr_pkg::TOTAL_W;
   localparam int NW = fpr_pkg::NUM_W;
   localparam int CW = fpr_pkg::DCNT_W;

   // Control state
   fpr_pkg::state_type state_ff, state_in;
   logic [DW-1:0]      budget_ff, budget_in;
   logic [TW-1:0]      deadline_ff, deadline_in;
   logic [HW-1:0]      head_ff, head_in;
   logic [OW-1:0]      total_ff, total_in;
   logic [SW-1:0]      seen_ff, seen_in;
   logic [RW-1:0]      rate_ff, rate_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Working and payload registers
   logic [TW-1:0]      now_ff, now_in;
   logic [TW-1:0]      release_ff, release_in;
   logic [DW-1:0]      dur_ff, dur_in;
   logic [OW-1:0]      rem_ff, rem_in;
   logic [NW-1:0]      quo_ff, quo_in;
   logic [TW-1:0]      rsp_release_ff, rsp_release_in;
   logic [DW-1:0]      rsp_dur_ff, rsp_dur_in;
   logic [RW-1:0]      rsp_rate_ff, rsp_rate_in;
   logic               rsp_rv_ff, rsp_rv_in;

   // Shared adder
   fpr_pkg::alu_op_type alu_op;
   logic [TW-1:0]       alu_a, alu_b, alu_sum;
   logic                alu_carry;

   // Ring memory
   logic               ram_wr_en, ram_rd_en;
   logic [DW-1:0]      ram_rd_data;
   logic [DW-1:0]      old_dur;

   // Divider helpers
   logic [CW-1:0]      num_idx;
   logic [OW:0]        trial;
   logic [NW-1:0]      quo_next;
   logic               window_full;
   logic               rsp_free;

   fpr_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   fpr_ram #(
      .WIDTH (DW),
      .DEPTH (fpr_pkg::WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (dur_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign csr_ready   = 1'b1;
   assign req_ready   = (state_ff == fpr_pkg::ST_IDLE);
   assign window_full = (seen_ff == SW'(fpr_pkg::WINDOW));
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   // Slots not yet written in the first pass are read as zero
   assign old_dur   = window_full ? ram_rd_data : '0;
   assign ram_rd_en = req_valid && req_ready;
   assign ram_wr_en = (state_ff == fpr_pkg::ST_ADD);

   // Restoring divide step: shift in the next numerator bit, MSB first
   assign num_idx  = CW'(NW - 1) - cnt_ff;
   assign trial    = {rem_ff, fpr_pkg::RATE_NUM[num_idx]};
   assign quo_next = {quo_ff[NW-2:0], alu_carry};

   // Shared adder operand selection
   always_comb begin
      alu_op = fpr_pkg::ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         fpr_pkg::ST_ADV: begin
            alu_a = deadline_ff;
            alu_b = TW'(budget_ff);
         end
         fpr_pkg::ST_CMP: begin
            alu_op = fpr_pkg::ALU_SUB;
            alu_a  = deadline_ff;
            alu_b  = now_ff;
         end
         fpr_pkg::ST_RST: begin
            alu_a = now_ff;
            alu_b = TW'(budget_ff);
         end
         fpr_pkg::ST_SUB: begin
            alu_op = fpr_pkg::ALU_SUB;
            alu_a  = TW'(total_ff);
            alu_b  = TW'(old_dur);
         end
         fpr_pkg::ST_ADD: begin
            alu_a = TW'(total_ff);
            alu_b = TW'(dur_ff);
         end
         fpr_pkg::ST_DIV: begin
            alu_op = fpr_pkg::ALU_SUB;
            alu_a  = TW'(trial);
            alu_b  = TW'(total_ff);
         end
         default: begin
            alu_op = fpr_pkg::ALU_ADD;
         end
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      budget_in      = budget_ff;
      deadline_in    = deadline_ff;
      head_in        = head_ff;
      total_in       = total_ff;
      seen_in        = seen_ff;
      rate_in        = rate_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      now_in         = now_ff;
      release_in     = release_ff;
      dur_in         = dur_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      rsp_release_in = rsp_release_ff;
      rsp_dur_in     = rsp_dur_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_rv_in      = rsp_rv_ff;

      if (csr_valid && csr_ready) begin
         budget_in = csr_frame_budget_ns;
      end

      // response taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         fpr_pkg::ST_IDLE: begin
            if (req_valid) begin
               now_in = req_now_ns;
               if (budget_ff == '0) begin
                  // pacing off: release at once
                  release_in = req_now_ns;
                  dur_in     = '0;
                  state_in   = fpr_pkg::ST_SUB;
               end else begin
                  state_in = fpr_pkg::ST_ADV;
               end
            end
         end
         fpr_pkg::ST_ADV: begin
            deadline_in = alu_sum;
            state_in    = fpr_pkg::ST_CMP;
         end
         fpr_pkg::ST_CMP: begin
            // carry set: deadline not behind the stamp
            if (alu_carry) begin
               release_in = deadline_ff;
               dur_in     = fpr_pkg::sat_dur(alu_sum);
               state_in   = fpr_pkg::ST_SUB;
            end else begin
               state_in = fpr_pkg::ST_RST;
            end
         end
         fpr_pkg::ST_RST: begin
            // deadline fell behind: restart from the stamp
            deadline_in = alu_sum;
            release_in  = alu_sum;
            dur_in      = budget_ff;
            state_in    = fpr_pkg::ST_SUB;
         end
         fpr_pkg::ST_SUB: begin
            total_in = alu_sum[OW-1:0];
            state_in = fpr_pkg::ST_ADD;
         end
         fpr_pkg::ST_ADD: begin
            total_in = alu_sum[OW-1:0];
            head_in  = (head_ff == HW'(fpr_pkg::WINDOW - 1)) ? '0 : head_ff + 1'b1;
            if (!window_full) begin
               seen_in = seen_ff + 1'b1;
            end
            if (window_full || (seen_ff == SW'(fpr_pkg::WINDOW - 1))) begin
               if (alu_sum[OW-1:0] == '0) begin
                  rate_in  = '0;
                  state_in = fpr_pkg::ST_DONE;
               end else begin
                  rem_in   = '0;
                  quo_in   = '0;
                  cnt_in   = '0;
                  state_in = fpr_pkg::ST_DIV;
               end
            end else begin
               state_in = fpr_pkg::ST_DONE;
            end
         end
         fpr_pkg::ST_DIV: begin
            rem_in = alu_carry ? alu_sum[OW-1:0] : trial[OW-1:0];
            quo_in = quo_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NW - 1)) begin
               rate_in  = (|quo_next[NW-1:RW]) ? {RW{1'b1}} : quo_next[RW-1:0];
               state_in = fpr_pkg::ST_DONE;
            end
         end
         fpr_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_release_in = release_ff;
               rsp_dur_in     = dur_ff;
               rsp_rate_in    = rate_ff;
               rsp_rv_in      = window_full;
               state_in       = fpr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fpr_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpr_pkg::ST_IDLE;
         budget_ff    <= '0;
         deadline_ff  <= '0;
         head_ff      <= '0;
         total_ff     <= '0;
         seen_ff      <= '0;
         rate_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         budget_ff    <= budget_in;
         deadline_ff  <= deadline_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         seen_ff      <= seen_in;
         rate_ff      <= rate_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      release_ff     <= release_in;
      dur_ff         <= dur_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      rsp_release_ff <= rsp_release_in;
      rsp_dur_ff     <= rsp_dur_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_rv_ff      <= rsp_rv_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_release_ns       = rsp_release_ff;
   assign rsp_wait_ns          = rsp_dur_ff;
   assign rsp_measured_rate_q8 = rsp_rate_ff;
   assign rsp_rate_valid       = rsp_rv_ff;

   // An accepted request goes straight to pacing or to the sum update
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (state_ff == fpr_pkg::ST_ADV || state_ff == fpr_pkg::ST_SUB))
      else $error("request accept did not start the sequencer");

   // The divider never runs against a zero sum
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fpr_pkg::ST_DIV) |-> (total_ff != '0))
      else $error("divide started with zero running total");

   // A reported valid rate implies a full window
   a_rate_valid_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rate_valid) |-> window_full)
      else $error("rate_valid set before the window filled");

   // Fill count never passes the window size
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      (seen_ff <= SW'(fpr_pkg::WINDOW)))
      else $error("frame count exceeded window");

endmodule
